>>> sv/sstf_pkg.sv
`default_nettype none
package sstf_pkg;

   localparam int MAX_REQUESTERS_DEF = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int QPW                = $clog2(QUEUE_DEPTH);
   localparam int QCW                = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] ACT_JOIN   = 2'd0;
   localparam logic [1:0] ACT_SUBMIT = 2'd1;
   localparam logic [1:0] ACT_LEAVE  = 2'd2;

   localparam logic [1:0] ST_ACCEPT  = 2'd0;
   localparam logic [1:0] ST_PENDING = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_DONE    = 2'd3;

   localparam logic [4:0] LIVE_MAX     = 5'd31;
   localparam logic [4:0] QLIMIT_RESET = 5'd1;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  requester_id;
      logic [15:0] track;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        served;
      logic [3:0]  served_requester;
      logic [15:0] served_track;
      logic [15:0] seek_distance;
   } rsp_type;

   typedef enum logic [2:0] {
      KIND_JOIN,
      KIND_SUBMIT,
      KIND_NOSLOT,
      KIND_LEAVE,
      KIND_NOP
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  id;
      logic [15:0] track;
   } qitem_type;

endpackage
`default_nettype wire

>>> sv/sstf_front.sv
`default_nettype none
module sstf_front #(
   parameter int MAX_REQUESTERS = sstf_pkg::MAX_REQUESTERS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   start,
   output logic                  busy,
   input  sstf_pkg::req_type     req_item,
   output logic                  q_valid,
   output sstf_pkg::qitem_type   q_item,
   input  wire                   q_pop
);
   import sstf_pkg::*;

   qitem_type            q_ff [QUEUE_DEPTH];
   logic [QPW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]       count_ff, count_in;
   qitem_type            cls;
   logic                 push;
   logic                 pop;

   always_comb begin
      cls.id    = req_item.requester_id;
      cls.track = req_item.track;
      case (req_item.action)
         ACT_JOIN:   cls.kind = KIND_JOIN;
         ACT_SUBMIT: cls.kind = (32'(req_item.requester_id) >= MAX_REQUESTERS) ?
                                KIND_NOSLOT : KIND_SUBMIT;
         ACT_LEAVE:  cls.kind = KIND_LEAVE;
         default:    cls.kind = KIND_NOP;
      endcase
   end

   assign busy    = (count_ff == QCW'(QUEUE_DEPTH));
   assign push    = start && !busy;
   assign q_valid = (count_ff != '0);
   assign pop     = q_pop && q_valid;
   assign q_item  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

>>> sv/sstf_back.sv
`default_nettype none
module sstf_back #(
   parameter int MAX_REQUESTERS = sstf_pkg::MAX_REQUESTERS_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  [4:0]            queue_limit,
   input  wire                   q_valid,
   input  sstf_pkg::qitem_type   q_item,
   output logic                  q_pop,
   output logic                  rsp_strobe,
   output sstf_pkg::rsp_type     rsp_item
);
   import sstf_pkg::*;

   localparam int SLOTS = (MAX_REQUESTERS < 16) ? MAX_REQUESTERS : 16;
   localparam int SW    = $clog2(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_SCAN = 4'b0100,
      S_FIN  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   qitem_type        cur_ff, cur_in;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [15:0]      track_ff [SLOTS];
   logic [15:0]      head_ff, head_in;
   logic [4:0]       live_ff, live_in;
   logic [4:0]       pend_ff, pend_in;
   logic [1:0]       status_ff, status_in;
   logic [SW-1:0]    cnt_ff, cnt_in;
   logic             found_ff, found_in;
   logic [SW-1:0]    best_ff, best_in;
   logic [15:0]      bestd_ff, bestd_in;
   logic [15:0]      bestt_ff, bestt_in;
   logic             strobe_ff, strobe_in;
   rsp_type          rsp_ff, rsp_in;
   logic             trk_we;
   logic [4:0]       lim;
   logic [4:0]       thresh;
   logic [SW-1:0]    slot;
   logic [15:0]      trk;
   logic [15:0]      seek_d;

   assign slot   = cur_ff.id[SW-1:0];
   assign trk    = track_ff[cnt_ff];
   assign seek_d = (trk >= head_ff) ? trk - head_ff : head_ff - trk;

   always_comb begin
      lim = queue_limit;
      if (queue_limit == '0) begin
         lim = 5'd1;
      end
      if (32'(queue_limit) > MAX_REQUESTERS) begin
         lim = 5'(MAX_REQUESTERS);
      end
   end

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      valid_in  = valid_ff;
      head_in   = head_ff;
      live_in   = live_ff;
      pend_in   = pend_ff;
      status_in = status_ff;
      cnt_in    = cnt_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bestd_in  = bestd_ff;
      bestt_in  = bestt_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      trk_we    = 1'b0;
      q_pop     = 1'b0;
      thresh    = '0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               cur_in   = q_item;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            status_in = ST_DONE;
            case (cur_ff.kind)
               KIND_JOIN: begin
                  if (live_ff < LIVE_MAX) begin
                     live_in = live_ff + 1'b1;
                  end
               end
               KIND_LEAVE: begin
                  if (live_ff != '0) begin
                     live_in = live_ff - 1'b1;
                  end
               end
               KIND_NOSLOT: status_in = ST_FULL;
               KIND_SUBMIT: begin
                  if (valid_ff[slot]) begin
                     status_in = ST_PENDING;
                  end else if (pend_ff >= lim) begin
                     status_in = ST_FULL;
                  end else begin
                     valid_in[slot] = 1'b1;
                     trk_we         = 1'b1;
                     pend_in        = pend_ff + 1'b1;
                     status_in      = ST_ACCEPT;
                  end
               end
               default: status_in = ST_DONE;
            endcase
            thresh   = (live_in < lim) ? live_in : lim;
            cnt_in   = '0;
            found_in = 1'b0;
            if (pend_in != '0 && pend_in >= thresh) begin
               state_in = S_SCAN;
            end else begin
               rsp_in    = '{status: status_in, served: 1'b0, served_requester: '0,
                             served_track: '0, seek_distance: '0};
               strobe_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_SCAN: begin
            if (valid_ff[cnt_ff] && (!found_ff || seek_d < bestd_ff)) begin
               found_in = 1'b1;
               best_in  = cnt_ff;
               bestd_in = seek_d;
               bestt_in = trk;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == SW'(SLOTS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            rsp_in = '{status: status_ff, served: 1'b0, served_requester: '0,
                       served_track: '0, seek_distance: '0};
            if (found_ff) begin
               rsp_in.served           = 1'b1;
               rsp_in.served_requester = 4'(best_ff);
               rsp_in.served_track     = bestt_ff;
               rsp_in.seek_distance    = bestd_ff;
               valid_in[best_ff]       = 1'b0;
               pend_in                 = pend_ff - 1'b1;
               head_in                 = bestt_ff;
            end
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         head_ff   <= '0;
         live_ff   <= '0;
         pend_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         head_ff   <= head_in;
         live_ff   <= live_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      status_ff <= status_in;
      cnt_ff    <= cnt_in;
      found_ff  <= found_in;
      best_ff   <= best_in;
      bestd_ff  <= bestd_in;
      bestt_ff  <= bestt_in;
      rsp_ff    <= rsp_in;
      if (trk_we) begin
         track_ff[slot] <= cur_ff.track;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule
`default_nettype wire

>>> sv/sstf_disk_request_scheduler.sv
// Each item goes from the queue through the back engine's S_IDLE and S_EXEC states
//   to rsp_strobe when nothing is dispatched, and also through S_SCAN and S_FIN
//   when a request is dispatched. The nearest-track scan covers N = min(MAX_REQUESTERS,
//   16) slots, one slot per cycle; the back engine pops the next item only in S_IDLE.
// A two-item queue holds accepted items; busy is high while it is full.
// Synchronous reset clears pending entries, head, counts and the queue; queue_limit -> 1.
`default_nettype none
module sstf_disk_request_scheduler #(
   parameter int MAX_REQUESTERS = sstf_pkg::MAX_REQUESTERS_DEF
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  sstf_pkg::req_type   req_item,
   output logic                rsp_strobe,
   output sstf_pkg::rsp_type   rsp_item,
   input  wire                 csr_we,
   input  wire  [4:0]          csr_wdata
);
   import sstf_pkg::*;

   logic [4:0] queue_limit_ff;
   logic       q_valid;
   logic       q_pop;
   qitem_type  q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= QLIMIT_RESET;
      end else if (csr_we) begin
         queue_limit_ff <= csr_wdata;
      end
   end

   sstf_front #(.MAX_REQUESTERS(MAX_REQUESTERS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   sstf_back #(.MAX_REQUESTERS(MAX_REQUESTERS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_limit (queue_limit_ff),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule
`default_nettype wire

>>> sv/sstf_checker.sv
`default_nettype none
module sstf_checker (
   input wire                 clock,
   input wire                 reset,
   input wire                 busy,
   input wire                 rsp_strobe,
   input sstf_pkg::rsp_type   rsp_item
);
   import sstf_pkg::*;

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_no_dispatch_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_item.served) |->
         (rsp_item.served_requester == '0 && rsp_item.served_track == '0 &&
          rsp_item.seek_distance == '0))
      else $error("dispatch fields nonzero without a dispatch");

   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_strobe && !busy))
      else $error("strobe or busy active right after reset");

endmodule

bind sstf_disk_request_scheduler sstf_checker u_sstf_checker (
   .clock      (clock),
   .reset      (reset),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
`default_nettype wire
